FILE: design/multi_slot_event_timer_scheduler_assert.svh
// Assertion macros for the event timer scheduler
`ifndef MULTI_SLOT_EVENT_TIMER_SCHEDULER_ASSERT_SVH
`define MULTI_SLOT_EVENT_TIMER_SCHEDULER_ASSERT_SVH
`ifndef ASSERT_OFF
`define MSETS_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define MSETS_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define MSETS_ASSERT_IMP(label, clk, rst, pre, post)
`define MSETS_ASSERT_NXT(label, clk, rst, pre, post)
`endif
`endif

FILE: design/mset_pkg.sv
// ---------------------------------------------------------------------------
// mset_pkg
// Shared types and codes of the event timer scheduler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mset_pkg;
   localparam logic [2:0] KIND_ALLOC   = 3'd0;
   localparam logic [2:0] KIND_FREE    = 3'd1;
   localparam logic [2:0] KIND_ARM     = 3'd2;
   localparam logic [2:0] KIND_DISARM  = 3'd3;
   localparam logic [2:0] KIND_ADVANCE = 3'd4;
   localparam logic [2:0] KIND_QUERY   = 3'd5;
   localparam logic [2:0] KIND_RESTART = 3'd6;
   localparam logic [2:0] KIND_SETTIME = 3'd7;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_UNUSED  = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic [63:0] NEVER_DUE = 64'hFFFF_FFFF_FFFF_FFFF;

   // one command as the front end queues it
   typedef struct packed {
      logic [2:0]  kind;
      logic [5:0]  slot;
      logic [63:0] time_arg;
      logic [63:0] period_arg;
      logic        repeat_req;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  slot_out;
      logic [63:0] time_out;
      logic        fired;
      logic        last;
   } rsp_type;
endpackage
`default_nettype wire

FILE: design/multi_slot_event_timer_scheduler.sv
// Multi-slot event timer scheduler.
// Command beats enter on req_ (tuser: kind; tdata: slot, time_arg,
// period_arg, repeat_req). Results leave on rsp_ (tdata: status, slot_out,
// time_out; tuser: fired; tlast marks the last result of a command).
// A two-entry queue parts the command front end from the slot engine.
// Free, arm, disarm, query and set time are carried out in the idle state;
// allocate searches the slots below the mark for a free one, restart sweeps
// them all, and advance sweeps them once, then once more per fired timer and
// once for the final result. The rate is set by the engine, which visits one
// slot a cycle within a sweep.
// Reset frees all slots and sets time to zero and next due to never; due
// times and periods keep their values.
// A stalled receiver holds the current result; the engine waits, and the
// queue takes up to two further commands before req_tready drops.
// ---------------------------------------------------------------------------
// multi_slot_event_timer_scheduler
// Top level of the event timer scheduler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module multi_slot_event_timer_scheduler #(
   parameter int NUM_SLOTS = 16
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // slot[5:0], time_arg[69:6], period_arg[133:70], repeat_req[134]
   input  wire [135:0]  req_tdata,
   // kind[2:0]
   input  wire [2:0]    req_tuser,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // status[1:0], slot_out[7:2], time_out[71:8]
   output logic [71:0]  rsp_tdata,
   // fired[0]
   output logic         rsp_tuser,
   output logic         rsp_tlast
);
   mset_pkg::cmd_type in_cmd, q_cmd;
   mset_pkg::rsp_type rsp;
   logic q_valid, q_ready;

   // unpack the command beat
   assign in_cmd.kind       = req_tuser;
   assign in_cmd.slot       = req_tdata[5:0];
   assign in_cmd.time_arg   = req_tdata[69:6];
   assign in_cmd.period_arg = req_tdata[133:70];
   assign in_cmd.repeat_req = req_tdata[134];

   mset_cmd_fifo u_fifo (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_cmd(in_cmd),
      .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
   );

   mset_engine #(.NUM_SLOTS(NUM_SLOTS)) u_engine (
      .clock(clock), .reset(reset),
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp(rsp)
   );

   // pack the result beat
   assign rsp_tdata = {rsp.time_out, rsp.slot_out, rsp.status};
   assign rsp_tuser = rsp.fired;
   assign rsp_tlast = rsp.last;
endmodule
`default_nettype wire

FILE: design/mset_cmd_fifo.sv
// ---------------------------------------------------------------------------
// mset_cmd_fifo
// Front end: accept command beats into a short queue for the engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mset_cmd_fifo (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   input  wire mset_pkg::cmd_type in_cmd,
   output logic                  out_valid,
   input  wire                   out_ready,
   output mset_pkg::cmd_type     out_cmd
);
   mset_pkg::cmd_type mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = mem_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

FILE: design/mset_engine.sv
// ---------------------------------------------------------------------------
// mset_engine
// Back end: carry out commands on the slot table, one slot a cycle in a sweep.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "multi_slot_event_timer_scheduler_assert.svh"
module mset_engine #(
   parameter int NUM_SLOTS = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                cmd_valid,
   output logic               cmd_ready,
   input  wire mset_pkg::cmd_type cmd,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output mset_pkg::rsp_type  rsp
);
   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int HW = $clog2(NUM_SLOTS + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;  // alloc search / restart sweep
   localparam logic [2:0] S_ADV0  = 3'd2;  // mark due slots pending, next_due over not-due slots
   localparam logic [2:0] S_FIND  = 3'd3;  // find earliest pending slot
   localparam logic [2:0] S_FIRE  = 3'd4;  // emit and update one slot
   localparam logic [2:0] S_OUT   = 3'd5;  // unused; the engine never enters it

   logic [2:0]  state_ff;
   mset_pkg::cmd_type cmd_ff;
   logic [63:0] now_ff, next_due_ff;
   logic [HW-1:0] hw_ff;
   logic [NUM_SLOTS-1:0] used_ff, armed_ff, cont_ff, pend_ff;
   logic [63:0] period_ff [NUM_SLOTS];
   logic [63:0] due_ff    [NUM_SLOTS];
   logic [HW-1:0] idx_ff;
   logic [IW-1:0] best_ff;
   logic          best_ok_ff;
   logic [63:0]   best_t_ff;
   logic          rvalid_ff;
   mset_pkg::rsp_type rsp_ff;

   logic [IW-1:0] cur, sidx;
   logic          s_valid;
   logic [63:0]   cur_due, cur_sum;

   assign cur     = idx_ff[IW-1:0];
   assign sidx    = cmd.slot[IW-1:0];
   assign s_valid = ({{(8-HW){1'b0}}, hw_ff} > {2'b00, cmd.slot}) &&
                    (cmd.slot < 6'(NUM_SLOTS));
   assign cur_due = due_ff[cur];
   assign cur_sum = due_ff[best_ff] + period_ff[best_ff];

   assign cmd_ready = (state_ff == S_IDLE) && !rvalid_ff;
   assign rsp_valid = rvalid_ff;
   assign rsp       = rsp_ff;

   function automatic mset_pkg::rsp_type mk(input logic [1:0] st, input logic [5:0] sl,
                                            input logic [63:0] t, input logic f,
                                            input logic l);
      mset_pkg::rsp_type r;
      r.status = st; r.slot_out = sl; r.time_out = t; r.fired = f; r.last = l;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rvalid_ff   <= 1'b0;
         now_ff      <= '0;
         next_due_ff <= mset_pkg::NEVER_DUE;
         hw_ff       <= '0;
         used_ff     <= '0;
         armed_ff    <= '0;
         cont_ff     <= '0;
         pend_ff     <= '0;
         idx_ff      <= '0;
         best_ok_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid && cmd_ready) begin
                  cmd_ff <= cmd;
                  idx_ff <= '0;
                  unique case (cmd.kind) inside
                     mset_pkg::KIND_ALLOC, mset_pkg::KIND_RESTART: begin
                        state_ff <= S_SCAN;
                        if (cmd.kind == mset_pkg::KIND_RESTART) begin
                           now_ff      <= '0;
                           next_due_ff <= mset_pkg::NEVER_DUE;
                        end
                     end
                     mset_pkg::KIND_ADVANCE: begin
                        next_due_ff <= mset_pkg::NEVER_DUE;
                        pend_ff     <= '0;
                        state_ff    <= S_ADV0;
                     end
                     mset_pkg::KIND_FREE, mset_pkg::KIND_ARM: begin
                        rvalid_ff <= 1'b1;
                        if (!s_valid) begin
                           rsp_ff <= mk(mset_pkg::ST_INVALID, '0, '0, 1'b0, 1'b1);
                        end else if (!used_ff[sidx]) begin
                           rsp_ff <= mk(mset_pkg::ST_UNUSED, '0, '0, 1'b0, 1'b1);
                        end else begin
                           rsp_ff <= mk(mset_pkg::ST_OK, '0, '0, 1'b0, 1'b1);
                           if (cmd.kind == mset_pkg::KIND_FREE) begin
                              used_ff[sidx]  <= 1'b0;
                              armed_ff[sidx] <= 1'b0;
                              if ({2'b00, cmd.slot} + 8'd1 == {{(8-HW){1'b0}}, hw_ff})
                                 hw_ff <= hw_ff - HW'(1);
                           end else begin
                              if (cmd.period_arg != '0) period_ff[sidx] <= cmd.period_arg;
                              armed_ff[sidx] <= 1'b1;
                              cont_ff[sidx]  <= cmd.repeat_req;
                              due_ff[sidx]   <= now_ff + cmd.time_arg;
                              if (now_ff + cmd.time_arg < next_due_ff)
                                 next_due_ff <= now_ff + cmd.time_arg;
                           end
                        end
                     end
                     mset_pkg::KIND_DISARM: begin
                        rvalid_ff <= 1'b1;
                        if (!s_valid) begin
                           rsp_ff <= mk(mset_pkg::ST_INVALID, '0, '0, 1'b0, 1'b1);
                        end else begin
                           armed_ff[sidx] <= 1'b0;
                           rsp_ff <= mk(mset_pkg::ST_OK, '0, '0, 1'b0, 1'b1);
                        end
                     end
                     mset_pkg::KIND_QUERY: begin
                        rvalid_ff <= 1'b1;
                        if (!s_valid) begin
                           rsp_ff <= mk(mset_pkg::ST_INVALID, '0, mset_pkg::NEVER_DUE,
                                        1'b0, 1'b1);
                        end else if (armed_ff[sidx] && due_ff[sidx] > now_ff) begin
                           rsp_ff <= mk(mset_pkg::ST_OK, '0, due_ff[sidx] - now_ff,
                                        1'b0, 1'b1);
                        end else begin
                           rsp_ff <= mk(mset_pkg::ST_OK, '0, '0, 1'b0, 1'b1);
                        end
                     end
                     mset_pkg::KIND_SETTIME: begin
                        now_ff    <= cmd.time_arg;
                        rvalid_ff <= 1'b1;
                        rsp_ff    <= mk(mset_pkg::ST_OK, '0, '0, 1'b0, 1'b1);
                     end
                     default: ;
                  endcase
               end else if (rsp_ready) begin
                  rvalid_ff <= 1'b0;
               end
            end
            S_SCAN: begin
               // walk slots below the mark
               if (idx_ff >= hw_ff) begin
                  state_ff  <= S_IDLE;
                  rvalid_ff <= 1'b1;
                  if (cmd_ff.kind == mset_pkg::KIND_RESTART) begin
                     rsp_ff <= mk(mset_pkg::ST_OK, '0, '0, 1'b0, 1'b1);
                  end else if (hw_ff >= HW'(NUM_SLOTS)) begin
                     rsp_ff <= mk(mset_pkg::ST_FULL, '0, '0, 1'b0, 1'b1);
                  end else begin
                     used_ff[hw_ff[IW-1:0]]   <= 1'b1;
                     armed_ff[hw_ff[IW-1:0]]  <= 1'b0;
                     cont_ff[hw_ff[IW-1:0]]   <= 1'b0;
                     period_ff[hw_ff[IW-1:0]] <= '0;
                     due_ff[hw_ff[IW-1:0]]    <= '0;
                     hw_ff <= hw_ff + HW'(1);
                     rsp_ff <= mk(mset_pkg::ST_OK, 6'(hw_ff), '0, 1'b0, 1'b1);
                  end
               end else if (cmd_ff.kind == mset_pkg::KIND_ALLOC) begin
                  if (!used_ff[cur]) begin
                     used_ff[cur]   <= 1'b1;
                     armed_ff[cur]  <= 1'b0;
                     cont_ff[cur]   <= 1'b0;
                     period_ff[cur] <= '0;
                     due_ff[cur]    <= '0;
                     rsp_ff    <= mk(mset_pkg::ST_OK, 6'(idx_ff), '0, 1'b0, 1'b1);
                     rvalid_ff <= 1'b1;
                     state_ff  <= S_IDLE;
                  end else begin
                     idx_ff <= idx_ff + HW'(1);
                  end
               end else begin
                  if (used_ff[cur] && armed_ff[cur] && cont_ff[cur])
                     due_ff[cur] <= period_ff[cur];
                  idx_ff <= idx_ff + HW'(1);
               end
            end
            S_ADV0: begin
               if (idx_ff >= hw_ff) begin
                  idx_ff     <= '0;
                  best_ok_ff <= 1'b0;
                  state_ff   <= S_FIND;
               end else begin
                  if (used_ff[cur] && armed_ff[cur]) begin
                     if (cur_due <= cmd_ff.time_arg) pend_ff[cur] <= 1'b1;
                     else if (cur_due < next_due_ff) next_due_ff <= cur_due;
                  end
                  idx_ff <= idx_ff + HW'(1);
               end
            end
            S_FIND: begin
               if (idx_ff >= hw_ff) begin
                  if (best_ok_ff) begin
                     state_ff <= S_FIRE;
                     if (rsp_ready) rvalid_ff <= 1'b0;
                  end else if (!rvalid_ff || rsp_ready) begin
                     now_ff    <= cmd_ff.time_arg;
                     rsp_ff    <= mk(mset_pkg::ST_OK, '0, next_due_ff, 1'b0, 1'b1);
                     rvalid_ff <= 1'b1;
                     state_ff  <= S_IDLE;
                  end
               end else begin
                  if (pend_ff[cur] && (!best_ok_ff || cur_due < best_t_ff)) begin
                     best_ok_ff <= 1'b1;
                     best_ff    <= cur;
                     best_t_ff  <= cur_due;
                  end
                  idx_ff <= idx_ff + HW'(1);
                  if (rsp_ready) rvalid_ff <= 1'b0;
               end
            end
            S_FIRE: begin
               if (!rvalid_ff || rsp_ready) begin
                  pend_ff[best_ff] <= 1'b0;
                  if (!cont_ff[best_ff]) begin
                     armed_ff[best_ff] <= 1'b0;
                  end else begin
                     due_ff[best_ff] <= cur_sum;
                     if (cur_sum < next_due_ff) next_due_ff <= cur_sum;
                  end
                  rsp_ff    <= mk(mset_pkg::ST_OK, 6'(best_ff), best_t_ff, 1'b1, 1'b0);
                  rvalid_ff <= 1'b1;
                  idx_ff     <= '0;
                  best_ok_ff <= 1'b0;
                  state_ff   <= S_FIND;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `MSETS_ASSERT_NXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `MSETS_ASSERT_IMP(a_hw, clock, reset, 1'b1, hw_ff <= HW'(NUM_SLOTS))
   `MSETS_ASSERT_IMP(a_busy, clock, reset, state_ff != S_IDLE, !cmd_ready)
   `MSETS_ASSERT_IMP(a_fire_pend, clock, reset, state_ff == S_FIRE, pend_ff[best_ff])
endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the event timer scheduler: directed command
// sequences, then random command streams, checked against a predictor of the
// slot table, with random stalls on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   localparam int NSLOT = 16;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  slot_out;
      logic [63:0] time_out;
      logic        fired;
      logic        last;
   } beat_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [135:0]  req_tdata;
   logic [2:0]    req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [71:0]   rsp_tdata;
   logic          rsp_tuser;
   logic          rsp_tlast;

   multi_slot_event_timer_scheduler #(.NUM_SLOTS(NSLOT)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   // predictor copy of the slot table
   logic [63:0] now_t;
   logic [63:0] next_t;
   int          hwm;
   logic        used_q [NSLOT];
   logic        armed_q [NSLOT];
   logic        cont_q [NSLOT];
   logic [63:0] period_q [NSLOT];
   logic [63:0] due_q [NSLOT];

   beat_type    expected_rsp [$];
   int          errors;
   bit          no_stall;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic report(input string what);
      errors++;
      $display("error at %0t: %s", $realtime, what);
   endtask

   function automatic beat_type mk(logic [1:0] st, logic [5:0] sl, logic [63:0] t,
                                   logic f, logic l);
      beat_type b;
      b.status = st; b.slot_out = sl; b.time_out = t; b.fired = f; b.last = l;
      return b;
   endfunction

   // work out the results of one command and update the table
   task automatic predict_cmd(input logic [2:0] kind, input logic [5:0] s,
                              input logic [63:0] targ, input logic [63:0] parg,
                              input logic rep);
      bit          ok;
      int          pick;
      int          best;
      bit          pend [NSLOT];
      logic [63:0] ft [NSLOT];
      ok = s < hwm;
      case (kind)
         mset_pkg::KIND_ALLOC: begin
            pick = -1;
            for (int i = 0; i < hwm; i++)
               if (!used_q[i] && pick < 0) pick = i;
            if (pick < 0 && hwm >= NSLOT) begin
               expected_rsp.push_back(mk(mset_pkg::ST_FULL, 0, 0, 0, 1));
            end else begin
               if (pick < 0) begin
                  pick = hwm;
                  hwm++;
               end
               used_q[pick] = 1; armed_q[pick] = 0; cont_q[pick] = 0;
               period_q[pick] = 0; due_q[pick] = 0;
               expected_rsp.push_back(mk(mset_pkg::ST_OK, pick[5:0], 0, 0, 1));
            end
         end
         mset_pkg::KIND_FREE, mset_pkg::KIND_ARM: begin
            if (!ok) expected_rsp.push_back(mk(mset_pkg::ST_INVALID, 0, 0, 0, 1));
            else if (!used_q[s]) expected_rsp.push_back(mk(mset_pkg::ST_UNUSED, 0, 0, 0, 1));
            else begin
               if (kind == mset_pkg::KIND_FREE) begin
                  used_q[s] = 0; armed_q[s] = 0;
                  if (s + 1 == hwm) hwm--;
               end else begin
                  if (parg != 0) period_q[s] = parg;
                  armed_q[s] = 1;
                  due_q[s] = now_t + targ;
                  cont_q[s] = rep;
                  if (due_q[s] < next_t) next_t = due_q[s];
               end
               expected_rsp.push_back(mk(mset_pkg::ST_OK, 0, 0, 0, 1));
            end
         end
         mset_pkg::KIND_DISARM: begin
            if (!ok) expected_rsp.push_back(mk(mset_pkg::ST_INVALID, 0, 0, 0, 1));
            else begin
               armed_q[s] = 0;
               expected_rsp.push_back(mk(mset_pkg::ST_OK, 0, 0, 0, 1));
            end
         end
         mset_pkg::KIND_ADVANCE: begin
            next_t = mset_pkg::NEVER_DUE;
            for (int i = 0; i < NSLOT; i++) begin
               pend[i] = 0;
               if (i < hwm && used_q[i] && armed_q[i]) begin
                  if (due_q[i] <= targ) begin
                     pend[i] = 1; ft[i] = due_q[i];
                  end else if (due_q[i] < next_t) next_t = due_q[i];
               end
            end
            forever begin
               best = -1;
               for (int i = 0; i < hwm; i++)
                  if (pend[i] && (best < 0 || ft[i] < ft[best])) best = i;
               if (best < 0) break;
               pend[best] = 0;
               if (!cont_q[best]) armed_q[best] = 0;
               else begin
                  due_q[best] = due_q[best] + period_q[best];
                  if (due_q[best] < next_t) next_t = due_q[best];
               end
               expected_rsp.push_back(mk(mset_pkg::ST_OK, best[5:0], ft[best], 1, 0));
            end
            now_t = targ;
            expected_rsp.push_back(mk(mset_pkg::ST_OK, 0, next_t, 0, 1));
         end
         mset_pkg::KIND_QUERY: begin
            if (!ok) expected_rsp.push_back(mk(mset_pkg::ST_INVALID, 0,
                                               mset_pkg::NEVER_DUE, 0, 1));
            else expected_rsp.push_back(mk(mset_pkg::ST_OK, 0,
               (armed_q[s] && due_q[s] > now_t) ? due_q[s] - now_t : 64'd0, 0, 1));
         end
         mset_pkg::KIND_RESTART: begin
            now_t = 0; next_t = mset_pkg::NEVER_DUE;
            for (int i = 0; i < hwm; i++)
               if (used_q[i] && armed_q[i] && cont_q[i]) due_q[i] = period_q[i];
            expected_rsp.push_back(mk(mset_pkg::ST_OK, 0, 0, 0, 1));
         end
         default: begin
            now_t = targ;
            expected_rsp.push_back(mk(mset_pkg::ST_OK, 0, 0, 0, 1));
         end
      endcase
   endtask

   // send one command beat after a random gap; valid stays up between
   // back-to-back beats
   task automatic send_cmd(input logic [2:0] kind, input logic [5:0] s,
                           input logic [63:0] targ, input logic [63:0] parg,
                           input logic rep);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      if (no_stall) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, rep, parg, targ, s};
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_cmd(kind, s, targ, parg, rep);
   endtask

   // result checker with random back-pressure
   initial begin
      beat_type got;
      beat_type want;
      int       hold;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         hold = no_stall ? 0 : $urandom_range(0, 16);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got = {rsp_tdata[1:0], rsp_tdata[7:2], rsp_tdata[71:8], rsp_tuser, rsp_tlast};
         if (expected_rsp.size() == 0) report("result beat with nothing expected");
         else begin
            want = expected_rsp.pop_front();
            if (got.status !== want.status)
               report($sformatf("status %0d want %0d", got.status, want.status));
            if (got.slot_out !== want.slot_out)
               report($sformatf("slot %0d want %0d", got.slot_out, want.slot_out));
            if (got.time_out !== want.time_out)
               report($sformatf("time %h want %h", got.time_out, want.time_out));
            if (got.fired !== want.fired)
               report($sformatf("fired %0b want %0b", got.fired, want.fired));
            if (got.last !== want.last)
               report($sformatf("last %0b want %0b", got.last, want.last));
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      for (int i = 0; i < NSLOT; i++) send_cmd(mset_pkg::KIND_ALLOC, 0, 0, 0, 0);
      send_cmd(mset_pkg::KIND_ALLOC, 0, 0, 0, 0);                       // table full
      send_cmd(mset_pkg::KIND_ARM, 0, 64'd5, 64'd3, 1);                 // continuous
      send_cmd(mset_pkg::KIND_ARM, 1, 64'd5, 0, 0);                     // tie, one-shot
      send_cmd(mset_pkg::KIND_ARM, 2, 64'd2, 0, 1);                     // zero period
      send_cmd(mset_pkg::KIND_ARM, 15, mset_pkg::NEVER_DUE, mset_pkg::NEVER_DUE, 0);
      send_cmd(mset_pkg::KIND_QUERY, 0, 0, 0, 0);
      send_cmd(mset_pkg::KIND_QUERY, 63, 0, 0, 0);                      // invalid slot
      send_cmd(mset_pkg::KIND_ADVANCE, 0, 64'd10, 0, 0);
      send_cmd(mset_pkg::KIND_QUERY, 2, 0, 0, 0);                       // overdue
      send_cmd(mset_pkg::KIND_ADVANCE, 0, 64'd4, 0, 0);                 // backwards
      send_cmd(mset_pkg::KIND_DISARM, 3, 0, 0, 0);
      send_cmd(mset_pkg::KIND_FREE, 15, 0, 0, 0);
      send_cmd(mset_pkg::KIND_FREE, 15, 0, 0, 0);                       // now invalid
      send_cmd(mset_pkg::KIND_FREE, 5, 0, 0, 0);
      send_cmd(mset_pkg::KIND_FREE, 5, 0, 0, 0);                        // not in use
      send_cmd(mset_pkg::KIND_ARM, 5, 1, 1, 1);                         // not in use
      send_cmd(mset_pkg::KIND_DISARM, 5, 0, 0, 0);
      send_cmd(mset_pkg::KIND_RESTART, 0, 0, 0, 0);
      send_cmd(mset_pkg::KIND_SETTIME, 0, mset_pkg::NEVER_DUE - 1, 0, 0);
      send_cmd(mset_pkg::KIND_ARM, 4, 64'd9, 0, 0);                     // wraps
      send_cmd(mset_pkg::KIND_ADVANCE, 0, mset_pkg::NEVER_DUE, 0, 0);
      wait_drained();
   endtask

   task automatic test_random(input int count);
      logic [2:0]  k;
      logic [63:0] ta;
      logic [63:0] pa;
      int          r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 12) k = mset_pkg::KIND_ALLOC;
         else if (r < 22) k = mset_pkg::KIND_FREE;
         else if (r < 45) k = mset_pkg::KIND_ARM;
         else if (r < 52) k = mset_pkg::KIND_DISARM;
         else if (r < 75) k = mset_pkg::KIND_ADVANCE;
         else if (r < 88) k = mset_pkg::KIND_QUERY;
         else if (r < 92) k = mset_pkg::KIND_RESTART;
         else k = mset_pkg::KIND_SETTIME;
         // mostly near-term times, sometimes any 64-bit value
         ta = ($urandom_range(0, 9) == 0) ? rand64() : now_t + $urandom_range(0, 60);
         if (k == mset_pkg::KIND_ARM) ta = ($urandom_range(0, 9) == 0) ? rand64()
                                                                      : $urandom_range(0, 50);
         pa = ($urandom_range(0, 9) == 0) ? rand64() : $urandom_range(0, 30);
         send_cmd(k, ($urandom_range(0, 9) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 17)),
                  ta, pa, 1'($urandom()));
         if (n == count / 2) begin
            // drain fully, then run a burst with no idling at all
            wait_drained();
            no_stall = 1;
         end
         if (n == count / 2 + 40) no_stall = 0;
      end
      wait_drained();
   endtask

   initial begin
      errors = 0; no_stall = 0;
      now_t = 0; next_t = mset_pkg::NEVER_DUE; hwm = 0;
      for (int i = 0; i < NSLOT; i++) begin
         used_q[i] = 0; armed_q[i] = 0; cont_q[i] = 0; period_q[i] = 0; due_q[i] = 0;
      end
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(420);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire
